>>> rtl/slto_pkg.sv
// ---------------------------------------------------------------------------
// slto_pkg
// Shared types and codes for the strong-liar order check.
// ---------------------------------------------------------------------------
package slto_pkg;

    localparam int MOD_BITS  = 32;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_FACTORS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRIME_0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIME_1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRIME_2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRIME_3     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PRIME_4     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRIME_5     = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MOD_START,
        ST_MOD_WAIT,
        ST_SPLIT,
        ST_POW_MUL,
        ST_POW_MUL_WAIT,
        ST_POW_SQR,
        ST_POW_SQR_WAIT,
        ST_ORD_CHECK,
        ST_ORD_WAIT,
        ST_NEXT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic reduce;
    } mm_ctrl_t;

endpackage

>>> rtl/slto_modmul.sv
// ---------------------------------------------------------------------------
// slto_modmul
// Bit-serial modular multiplier, one bit of y per cycle (double and add).
// With reduce set it computes x mod m instead (y taken as 1 over W bits).
// ---------------------------------------------------------------------------
module slto_modmul
    import slto_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  mm_ctrl_t     ctrl,
    input  logic [W-1:0] x,
    input  logic [W-1:0] y,
    input  logic [W-1:0] m,
    output logic         done,
    output logic [W-1:0] result
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [W:0]    r_reg;
    logic [W-1:0]  x_reg;
    logic [W-1:0]  y_reg;
    logic [W-1:0]  m_reg;
    logic          red_reg;
    logic          done_reg;

    logic [W+1:0] dbl;
    logic [W+1:0] d_red;
    logic [W+1:0] add;
    logic [W+1:0] r_next;
    logic         bit_now;

    always_comb
    begin
        bit_now = y_reg[W-1];
        add     = '0;
        if (red_reg)
        begin
            // shift x in MSB first: r = 2r + bit, reduce
            dbl   = {r_reg, 1'b0} + {{(W+1){1'b0}}, x_reg[W-1]};
            d_red = (dbl >= {2'b00, m_reg}) ? dbl - {2'b00, m_reg} : dbl;
            r_next = d_red;
        end
        else
        begin
            dbl   = {r_reg, 1'b0};
            d_red = (dbl >= {2'b00, m_reg}) ? dbl - {2'b00, m_reg} : dbl;
            add   = d_red + {2'b00, x_reg};
            r_next = bit_now ? ((add >= {2'b00, m_reg}) ? add - {2'b00, m_reg} : add) : d_red;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start && !busy_reg)
        begin
            r_reg   <= '0;
            x_reg   <= x;
            y_reg   <= y;
            m_reg   <= m;
            red_reg <= ctrl.reduce;
        end
        else if (busy_reg)
        begin
            r_reg <= r_next[W:0];
            y_reg <= {y_reg[W-2:0], 1'b0};
            if (red_reg)
            begin
                x_reg <= {x_reg[W-2:0], 1'b0};
            end
        end
    end

    assign done   = done_reg;
    assign result = r_reg[W-1:0];

endmodule

>>> rtl/strong_liar_two_adic_order_check.sv
// ---------------------------------------------------------------------------
// strong_liar_two_adic_order_check
// Classifies a base as strong liar or witness for a composite n given by
// its distinct prime factors.
// ---------------------------------------------------------------------------
// Usage:
//   s_tvalid/s_tready/s_tdata carry one 32-bit candidate base a per beat.
//   m_tvalid/m_tready/m_tdata return one result beat per candidate:
//   tdata[0] is_liar, tdata[5:1] first_order.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write registers while idle:
//   index 0 num_factors, 1..MAX_FACTORS the primes.
//   Each prime costs one reduction of a mod p, square-and-multiply for a^d
//   and up to e squarings on the single shared bit-serial modular multiplier;
//   at most 65 products per prime, each issued from its own dispatch state.
//   s_tready is low while a candidate is in work and while the result waits.
//   A stalled receiver holds the result; no new candidate is taken until it
//   leaves. Reset restores num_factors 3 and primes 3, 11, 17, 3, 3, 3.
// ---------------------------------------------------------------------------
module strong_liar_two_adic_order_check
    import slto_pkg::*;
#(
    parameter int MAX_FACTORS = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [31:0] candidate
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [0] is_liar, [5:1] first_order
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int W  = MOD_BITS;
    localparam int FW = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
    localparam int EW = $clog2(W + 1);

    state_t state_reg, state_next;

    logic [2:0]    nf_reg;
    logic [W-1:0]  primes_reg [MAX_FACTORS];
    logic [31:0]   a_reg;
    logic [FW-1:0] idx_reg;
    logic [FW:0]   cnt_eff;
    logic [W-1:0]  p_load;
    logic [W-1:0]  p_reg;
    logic [W-1:0]  b_reg;
    logic [W-1:0]  r_reg;
    logic [W-1:0]  d_reg;
    logic [EW-1:0] e_reg;
    logic [EW-1:0] k_reg;
    logic [4:0]    first_reg;
    logic          div_reg;
    logic          liar_reg;
    logic          out_valid_reg;
    logic          out_liar_reg;
    logic [4:0]    out_first_reg;

    mm_ctrl_t      mm_ctrl;
    logic [W-1:0]  mm_x, mm_y, mm_res;
    logic          mm_done;
    logic [W-1:0]  a_ext;

    assign a_ext  = a_reg;
    assign p_load = primes_reg[idx_reg];

    always_comb
    begin
        if (nf_reg == 3'd0)
            cnt_eff = (FW+1)'(1);
        else if (32'(nf_reg) > MAX_FACTORS)
            cnt_eff = (FW+1)'(MAX_FACTORS);
        else
            cnt_eff = (FW+1)'(nf_reg);
    end

    slto_modmul #(.W(W)) u_mm
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mm_ctrl),
        .x      (mm_x),
        .y      (mm_y),
        .m      (p_reg),
        .done   (mm_done),
        .result (mm_res)
    );

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00, out_first_reg, out_liar_reg};

    always_comb
    begin
        state_next     = state_reg;
        mm_ctrl.start  = 1'b0;
        mm_ctrl.reduce = 1'b0;
        mm_x           = b_reg;
        mm_y           = b_reg;
        case (state_reg)
            ST_IDLE:
                if (s_tvalid && s_tready) state_next = ST_LOAD;
            ST_LOAD:
                state_next = (p_load < W'(2)) ? ST_NEXT : ST_MOD_START;
            ST_MOD_START:
            begin
                mm_ctrl.start  = 1'b1;
                mm_ctrl.reduce = 1'b1;
                mm_x           = a_ext;
                state_next     = ST_MOD_WAIT;
            end
            ST_MOD_WAIT:
                if (mm_done) state_next = ST_SPLIT;
            ST_SPLIT:
                if (b_reg == '0) state_next = ST_NEXT;
                else if (!d_reg[0]) state_next = ST_SPLIT;
                else state_next = ST_POW_MUL;
            ST_POW_MUL:
            begin
                if (d_reg == '0)
                    state_next = ST_ORD_CHECK;
                else if (d_reg[0])
                begin
                    mm_ctrl.start = 1'b1;
                    mm_x          = r_reg;
                    state_next    = ST_POW_MUL_WAIT;
                end
                else
                    state_next = ST_POW_SQR;
            end
            ST_POW_MUL_WAIT:
                if (mm_done) state_next = ST_POW_SQR;
            ST_POW_SQR:
            begin
                mm_ctrl.start = 1'b1;
                state_next    = ST_POW_SQR_WAIT;
            end
            ST_POW_SQR_WAIT:
                if (mm_done) state_next = ST_POW_MUL;
            ST_ORD_CHECK:
            begin
                if (r_reg == W'(1) || k_reg >= e_reg)
                    state_next = ST_NEXT;
                else
                begin
                    mm_ctrl.start = 1'b1;
                    mm_x          = r_reg;
                    mm_y          = r_reg;
                    state_next    = ST_ORD_WAIT;
                end
            end
            ST_ORD_WAIT:
                if (mm_done) state_next = ST_ORD_CHECK;
            ST_NEXT:
                state_next = ((FW+1)'(idx_reg) + 1'b1 >= cnt_eff) ? ST_DONE : ST_LOAD;
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            nf_reg        <= 3'd3;
            for (int i = 0; i < MAX_FACTORS; i++)
            begin
                primes_reg[i] <= W'(3);
            end
            if (MAX_FACTORS > 1) primes_reg[1 % MAX_FACTORS] <= W'(11);
            if (MAX_FACTORS > 2) primes_reg[2 % MAX_FACTORS] <= W'(17);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_NUM_FACTORS)
                    nf_reg <= cfg_data[2:0];
                else if (32'(cfg_index) <= MAX_FACTORS)
                    primes_reg[FW'(cfg_index - REG_PRIME_0)] <= cfg_data[W-1:0];
            end
            if (state_reg == ST_DONE)
                out_valid_reg <= 1'b1;
            else if (m_tvalid && m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (s_tvalid && s_tready)
                begin
                    a_reg     <= s_tdata;
                    idx_reg   <= '0;
                    div_reg   <= (s_tdata == 32'd0);
                    liar_reg  <= 1'b1;
                    first_reg <= '0;
                end
            ST_LOAD:
            begin
                p_reg <= p_load;
                if (p_load < W'(2))
                    div_reg <= 1'b1;
                d_reg <= p_load - W'(1);
                e_reg <= '0;
                k_reg <= '0;
                r_reg <= W'(1);
            end
            ST_MOD_WAIT:
                if (mm_done) b_reg <= mm_res;
            ST_SPLIT:
                if (b_reg == '0)
                    div_reg <= 1'b1;
                else if (!d_reg[0])
                begin
                    d_reg <= d_reg >> 1;
                    e_reg <= e_reg + 1'b1;
                end
            ST_POW_MUL_WAIT:
                if (mm_done) r_reg <= mm_res;
            ST_POW_SQR_WAIT:
                if (mm_done)
                begin
                    b_reg <= mm_res;
                    d_reg <= d_reg >> 1;
                end
            ST_ORD_CHECK:
                if (r_reg == W'(1) || k_reg >= e_reg)
                begin
                    if (r_reg != W'(1)) liar_reg <= 1'b0;
                    // counts never exceed 31, so five bits compare exactly
                    if (idx_reg == '0)
                        first_reg <= 5'(k_reg);
                    else if (5'(k_reg) != first_reg)
                        liar_reg <= 1'b0;
                end
            ST_ORD_WAIT:
                if (mm_done)
                begin
                    r_reg <= mm_res;
                    k_reg <= k_reg + 1'b1;
                end
            ST_NEXT:
                idx_reg <= idx_reg + 1'b1;
            ST_DONE:
            begin
                out_liar_reg  <= liar_reg && !div_reg;
                out_first_reg <= div_reg ? 5'd0 : first_reg;
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input accepted while busy");
    a_done_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> m_tvalid)
        else $error("result not presented");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped under stall");
`endif

endmodule

>>> test/tb.sv
// ---------------------------------------------------------------------------
// tb
// Checks the strong-liar order check against a behavioral predictor of the
// 2-adic order test, over several prime sets, with random stalls on both sides.
// ---------------------------------------------------------------------------
module tb
    import slto_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NFAC = 6;

    typedef struct packed {
        logic       is_liar;
        logic [4:0] first_order;
    } verdict_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    logic [2:0]  factor_cnt;
    logic [31:0] prime_set [NFAC];

    logic [31:0] base_q [$];
    verdict_t    verdict_q [$];
    int          mismatches = 0;
    int          hold_cycles = 0;
    int          gap_cycles = 0;
    bit          hold_arm = 0;
    bit          hold_used = 0;
    bit          stim_done = 0;

    strong_liar_two_adic_order_check uut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] mulmod(logic [31:0] x, logic [31:0] y, logic [31:0] m);
        logic [63:0] p;
        p = 64'(x) * 64'(y);
        return 32'(p % 64'(m));
    endfunction

    function automatic logic [31:0] powmod(logic [31:0] b, logic [31:0] ex, logic [31:0] m);
        logic [31:0] r;
        r = 32'd1;
        b = b % m;
        while (ex != 0)
        begin
            if (ex[0]) r = mulmod(r, b, m);
            b = mulmod(b, b, m);
            ex = ex >> 1;
        end
        return r;
    endfunction

    function automatic verdict_t classify(logic [31:0] a);
        int          n;
        logic [31:0] p, d, v;
        int          e, k;
        int          order [NFAC];
        bit          hit [NFAC];
        bit          divisible;
        verdict_t    res;
        n = (factor_cnt == 0) ? 1 : (factor_cnt > NFAC) ? NFAC : factor_cnt;
        divisible = (a == 0);
        for (int i = 0; i < n; i++)
        begin
            p = prime_set[i];
            order[i] = 0;
            hit[i] = 0;
            if (p < 2 || a % p == 0)
            begin
                divisible = 1;
                continue;
            end
            d = p - 32'd1;
            e = 0;
            while (d[0] == 1'b0)
            begin
                d = d >> 1;
                e++;
            end
            v = powmod(a, d, p);
            k = 0;
            while (v != 1 && k < e)
            begin
                v = mulmod(v, v, p);
                k++;
            end
            order[i] = k;
            hit[i] = (v == 1);
        end
        if (divisible)
            return '0;
        res.is_liar = 1'b1;
        for (int i = 0; i < n; i++)
            if (!hit[i] || order[i] != order[0]) res.is_liar = 1'b0;
        res.first_order = 5'(order[0]);
        return res;
    endfunction

    // drive candidates with random gaps, mostly short and now and then long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && !s_tready))
            ;
        else if (gap_cycles > 0)
        begin
            gap_cycles <= gap_cycles - 1;
            s_tvalid   <= 1'b0;
        end
        else if (base_q.size() != 0)
        begin
            s_tvalid   <= 1'b1;
            s_tdata    <= base_q.pop_front();
            gap_cycles <= ($urandom_range(0, 19) == 0) ? int'($urandom_range(20, 200))
                                                       : int'($urandom_range(0, 3));
        end
        else
            s_tvalid <= 1'b0;
    end

    always @(posedge clk)
        if (rst_n && s_tvalid && s_tready)
            verdict_q = {verdict_q, classify(s_tdata)};

    // receiver stall, with one long hold-off once armed
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else if (hold_arm && !hold_used)
        begin
            hold_cycles <= 3000;
            hold_used   <= 1'b1;
            m_tready    <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 9) < 7);
    end

    always @(posedge clk)
    begin
        verdict_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.is_liar     = m_tdata[0];
            got.first_order = m_tdata[5:1];
            if (verdict_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", m_tdata);
            end
            else
            begin
                want = verdict_q.pop_front();
                if (got !== want || m_tdata[7:6] !== 2'b00)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: liar exp %b got %b, order exp %0d got %0d",
                                 want.is_liar, got.is_liar, want.first_order,
                                 got.first_order);
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_NUM_FACTORS) factor_cnt = val[2:0];
        else if (idx <= NFAC) prime_set[idx - REG_PRIME_0] = val;
    endtask

    task automatic drain();
        while (base_q.size() != 0 || s_tvalid || verdict_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic run_randoms(int count, int small_mod);
        logic [31:0] a;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 5))
                0: a = $urandom_range(0, 40);
                1: a = prime_set[$urandom_range(0, NFAC-1)] * $urandom_range(0, 50);
                2: a = small_mod ? $urandom_range(0, 5000) : $urandom;
                default: a = $urandom;
            endcase
            base_q = {base_q, a};
        end
    endtask

    initial
    begin
        factor_cnt = 3;
        prime_set = '{32'd3, 32'd11, 32'd17, 32'd3, 32'd3, 32'd3};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration: Carmichael 561, directed extremes
        base_q = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd11, 32'd17, 32'd50, 32'd560,
                   32'd562, 32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555,
                   32'hAAAA_AAAA, 32'd103, 32'd188};
        drain();

        // six factors, three of them near the top of the range, plus index beyond the list
        write_reg(REG_NUM_FACTORS, 32'd6);
        write_reg(REG_PRIME_0, 32'd4294967291);
        write_reg(REG_PRIME_1, 32'd4294967279);
        write_reg(REG_PRIME_2, 32'd7);
        write_reg(REG_PRIME_3, 32'd13);
        write_reg(REG_PRIME_4, 32'd4294967197);
        write_reg(REG_PRIME_5, 32'd97);
        write_reg(REG_PRIME_5 + 3'd1, 32'hDEAD_BEEF);
        base_q = '{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFA, 32'd4294967290, 32'd91};
        run_randoms(20, 0);
        drain();

        // factor count zero; prime_0 not prime, then modulus below two
        write_reg(REG_NUM_FACTORS, 32'd0);
        write_reg(REG_PRIME_0, 32'd9);
        base_q = '{32'd2, 32'd8, 32'd10, 32'd1};
        run_randoms(15, 1);
        drain();
        write_reg(REG_PRIME_0, 32'd1);
        base_q = '{32'd5, 32'd7};
        drain();
        write_reg(REG_PRIME_0, 32'd0);
        write_reg(REG_NUM_FACTORS, 32'd7);
        base_q = '{32'd5};
        drain();

        // small Carmichael 1105 = 5*13*17; long receiver hold-off
        write_reg(REG_NUM_FACTORS, 32'd3);
        write_reg(REG_PRIME_0, 32'd5);
        write_reg(REG_PRIME_1, 32'd13);
        write_reg(REG_PRIME_2, 32'd17);
        run_randoms(10, 1);
        hold_arm = 1;
        drain();

        // 2821 = 7*13*31 and 41041 = 7*11*13*41, about half of the bases small
        write_reg(REG_PRIME_0, 32'd7);
        write_reg(REG_PRIME_1, 32'd13);
        write_reg(REG_PRIME_2, 32'd31);
        run_randoms(80, 1);
        drain();
        write_reg(REG_NUM_FACTORS, 32'd4);
        write_reg(REG_PRIME_1, 32'd11);
        write_reg(REG_PRIME_2, 32'd13);
        write_reg(REG_PRIME_3, 32'd41);
        run_randoms(80, 1);
        drain();

        // large primes, two factors
        write_reg(REG_NUM_FACTORS, 32'd2);
        write_reg(REG_PRIME_0, 32'd2147483647);
        write_reg(REG_PRIME_1, 32'd4294967291);
        run_randoms(60, 0);
        drain();
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("status: fail");
        $finish;
    end
endmodule

>>> sim.f
rtl/slto_pkg.sv
rtl/slto_modmul.sv
rtl/strong_liar_two_adic_order_check.sv
test/tb.sv
